// File: sv/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg
// Shared types and constants for the banked sample logger.
// ----------------------------------------------------------------------------
package bsl_pkg;

	// default geometry
	localparam int BANKS_DEF            = 4;
	localparam int SAMPLES_PER_BANK_DEF = 1024;
	localparam int SAMPLE_WORDS_DEF     = 4;

	// fixed field widths
	localparam int WORD_W   = 16;
	localparam int MAX_WORDS = 4;
	localparam int WORDS_W  = WORD_W * MAX_WORDS;
	localparam int OFFS_W   = 16;
	localparam int POS_W    = 12;
	localparam int OP_W     = 2;

	// stream widths
	localparam int S_DATA_W = 80;
	localparam int M_DATA_W = 80;

	typedef enum logic [OP_W-1:0] {
		OP_CLEAR = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2,
		OP_MOVE  = 2'd3
	} op_t;

	// access request from counter unit to datapath
	typedef struct packed {
		logic wr;     // store sample at addr
		logic rd;     // read request
		logic empty;  // read found nothing unread
	} acc_t;

endpackage

// File: sv/bsl_ram.sv
// ----------------------------------------------------------------------------
// bsl_ram
// Generic single-port RAM, registered read with read enable.
// ----------------------------------------------------------------------------
module bsl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		// rdata holds while re is low
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// File: sv/bsl_ctrl.sv
// ----------------------------------------------------------------------------
// bsl_ctrl
// Write/read count registers and their update per request.
// ----------------------------------------------------------------------------
module bsl_ctrl #(
	parameter int BANKS            = bsl_pkg::BANKS_DEF,
	parameter int SAMPLES_PER_BANK = bsl_pkg::SAMPLES_PER_BANK_DEF,
	localparam int DEPTH = BANKS * SAMPLES_PER_BANK,
	localparam int CW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  bsl_pkg::op_t                op,
	input  logic [bsl_pkg::OFFS_W-1:0]  offset,
	output logic [CW-1:0]               addr,
	output bsl_pkg::acc_t               acc,
	output logic [CW-1:0]               rc_next,
	output logic [CW-1:0]               wc
);

	localparam int XW = ((CW > bsl_pkg::OFFS_W) ? CW : bsl_pkg::OFFS_W) + 2;

	logic [CW-1:0] wc_q, rc_q, wc_d, rc_d;
	logic [XW-1:0] rc_x, wc_x, offs_x, mag, fwd, base, bwd, mv, wc_inc;
	logic          empty;

	assign rc_x   = XW'(rc_q);
	assign wc_x   = XW'(wc_q);
	assign offs_x = XW'(offset);
	// magnitude of a negative offset, 1..32768
	assign mag    = XW'(17'h10000 - {1'b0, offset});
	assign fwd    = rc_x + offs_x;
	assign base   = (rc_x < mag) ? rc_x + wc_x : rc_x;
	assign bwd    = (base < mag) ? '0 : base - mag;
	assign mv     = offset[bsl_pkg::OFFS_W-1] ? bwd : ((fwd > wc_x) ? wc_x : fwd);
	assign wc_inc = wc_x + XW'(1);
	assign empty  = (rc_q >= wc_q);

	always_comb begin
		wc_d      = wc_q;
		rc_d      = rc_q;
		addr      = rc_q;
		acc       = '0;
		case (op)
			bsl_pkg::OP_CLEAR: begin
				wc_d = '0;
				rc_d = '0;
			end
			bsl_pkg::OP_WRITE: begin
				acc.wr = 1'b1;
				addr   = wc_q;
				// wrap to start once the store is full
				wc_d   = (wc_inc >= XW'(DEPTH)) ? '0 : wc_inc[CW-1:0];
			end
			bsl_pkg::OP_READ: begin
				acc.rd    = 1'b1;
				acc.empty = empty;
				if (!empty) begin
					rc_d = rc_q + CW'(1);
				end
			end
			bsl_pkg::OP_MOVE: begin
				rc_d = mv[CW-1:0];
			end
			default: begin
				rc_d = rc_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q <= '0;
			rc_q <= '0;
		end else if (go) begin
			wc_q <= wc_d;
			rc_q <= rc_d;
		end
	end

	assign rc_next = rc_d;
	assign wc      = wc_q;

endmodule

// File: sv/banked_sample_logger_top.sv
// ----------------------------------------------------------------------------
// banked_sample_logger_top
// Circular sample log over a banked store, with write, read, move and clear.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: operation; tdata: words 0..3, move_offset
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: read words 0..3, read_position
//
// One request per cycle while the response is not stalled. Counts update
// at the accept edge; the store (one RAM, address = running count, bank =
// upper bits) is read or written at that edge, and the response then moves
// from stage 1 into the output register and leaves from there.
// A stalled response holds the stage behind it; the input takes a new
// request whenever that stage can move on. Reset clears counts and valids
// only; store contents are undefined until written.
// ----------------------------------------------------------------------------
module banked_sample_logger_top #(
	parameter int BANKS            = bsl_pkg::BANKS_DEF,
	parameter int SAMPLES_PER_BANK = bsl_pkg::SAMPLES_PER_BANK_DEF,
	parameter int SAMPLE_WORDS     = bsl_pkg::SAMPLE_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [15:0] sample_word0, [31:16] sample_word1, [47:32] sample_word2,
	// [63:48] sample_word3, [79:64] move_offset
	input  logic [bsl_pkg::S_DATA_W-1:0]  s_tdata,
	// [1:0] operation
	input  logic [bsl_pkg::OP_W-1:0]      s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [15:0] read_word0, [31:16] read_word1, [47:32] read_word2,
	// [63:48] read_word3, [75:64] read_position, [79:76] zero
	output logic [bsl_pkg::M_DATA_W-1:0]  m_tdata,
	// [0] status
	output logic                          m_tuser
);

	localparam int DEPTH = BANKS * SAMPLES_PER_BANK;
	localparam int CW    = $clog2(DEPTH);
	localparam int RW    = SAMPLE_WORDS * bsl_pkg::WORD_W;

	logic                go, adv_s1;
	bsl_pkg::op_t        op;
	bsl_pkg::acc_t       acc;
	logic [CW-1:0]       addr, rc_next, wc;
	logic [RW-1:0]       rdata;

	// stage 1: store access in flight
	logic                valid_s1, hit_s1, empty_s1;
	logic [CW-1:0]       pos_s1;

	// output register
	logic                out_valid_q, out_empty_q;
	logic [bsl_pkg::M_DATA_W-1:0] out_data_q;

	logic [bsl_pkg::WORDS_W-1:0]  words;
	logic [bsl_pkg::POS_W+CW-1:0] pos_x;

	assign op       = bsl_pkg::op_t'(s_tuser);
	assign adv_s1   = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv_s1;
	assign go       = s_tvalid && s_tready;

	bsl_ctrl #(
		.BANKS            (BANKS),
		.SAMPLES_PER_BANK (SAMPLES_PER_BANK)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.op      (op),
		.offset  (s_tdata[bsl_pkg::WORDS_W +: bsl_pkg::OFFS_W]),
		.addr    (addr),
		.acc     (acc),
		.rc_next (rc_next),
		.wc      (wc)
	);

	// words are packed lowest first, so the kept ones are the low RW bits
	bsl_ram #(
		.WIDTH (RW),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (go && acc.wr),
		.re    (go && acc.rd && !acc.empty),
		.addr  (addr),
		.wdata (s_tdata[RW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (go) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			hit_s1   <= acc.rd && !acc.empty;
			empty_s1 <= acc.rd && acc.empty;
			pos_s1   <= rc_next;
		end
	end

	// only a successful read shows data; unused words stay zero
	assign words = hit_s1 ? bsl_pkg::WORDS_W'(rdata) : '0;
	assign pos_x = (bsl_pkg::POS_W + CW)'(pos_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && valid_s1) begin
			out_empty_q <= empty_s1;
			out_data_q  <= bsl_pkg::M_DATA_W'({pos_x[bsl_pkg::POS_W-1:0], words});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_empty_q;

	// write count always points inside the store
	a_wc_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(wc) < DEPTH)
		else $error("write count outside store");

	// an empty read never carries sample data
	a_empty_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[bsl_pkg::WORDS_W-1:0] == '0)
		else $error("empty read with data");

	// read data must hold while its response waits in stage 1
	a_hold_rdata: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && hit_s1 && !adv_s1 |=> $stable(rdata))
		else $error("store output changed under a stalled response");

	// a stalled stage 1 blocks new requests
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv_s1 |-> !go)
		else $error("request accepted over a stalled response");

endmodule
